[hdl/mftr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mftr_pkg
// shared types and constants for the multiframe transfer receiver
// ----------------------------------------------------------------------------
package mftr_pkg;

   localparam logic [1:0] STATUS_NONE   = 2'd0;
   localparam logic [1:0] STATUS_MULTI  = 2'd1;
   localparam logic [1:0] STATUS_SINGLE = 2'd2;

   localparam logic [0:0] CSR_MIN_INTERVAL = 1'b0;
   localparam logic [0:0] CSR_MAX_INTERVAL = 1'b1;

   localparam logic [31:0] MIN_INTERVAL_RESET = 32'd1000;
   localparam logic [31:0] MAX_INTERVAL_RESET = 32'd10000000;
   localparam logic [31:0] AVG_INTERVAL_RESET = 32'd500000;

   localparam logic [1:0] CRC_BYTES = 2'd2;

   // classified frame entering the reassembly engine
   typedef struct packed {
      logic [1:0]  iface;
      logic [7:0]  tid;
      logic [7:0]  idx;
      logic        last;
      logic [6:0]  plen;
      logic [15:0] head;
      logic [63:0] mono;
      logic [63:0] utc;
      logic        ts_ok;
      logic        first;
      logic        len_ok;
   } frame_type;

endpackage : mftr_pkg
`default_nettype wire

[hdl/mftr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mftr_front
// accepts frames, masks ids and classifies them into a two entry queue
// ----------------------------------------------------------------------------
module mftr_front
   import mftr_pkg::*;
#(
   parameter int TID_BITS    = 3,
   parameter int INDEX_BITS  = 6,
   parameter int MAX_PAYLOAD = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  iface,
   input  wire logic [2:0]  transfer_id,
   input  wire logic [5:0]  frame_index,
   input  wire logic        last_frame,
   input  wire logic [3:0]  byte_count,
   input  wire logic [15:0] head_bytes,
   input  wire logic [63:0] mono_ts,
   input  wire logic [63:0] utc_ts,
   output logic             frm_valid,
   input  wire logic        frm_take,
   output frame_type        frm
);

   localparam logic [7:0] TID_MASK = 8'((1 << TID_BITS) - 1);
   localparam logic [7:0] IDX_MASK = 8'((1 << INDEX_BITS) - 1);

   frame_type   q_ff [2];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   frame_type   f;
   logic        do_push, do_pop;

   always_comb begin
      f        = '0;
      f.iface  = iface;
      f.tid    = 8'(transfer_id) & TID_MASK;
      f.idx    = 8'(frame_index) & IDX_MASK;
      f.last   = last_frame;
      f.plen   = 7'(byte_count);
      f.head   = head_bytes;
      f.mono   = mono_ts;
      f.utc    = utc_ts;
      f.first  = (f.idx == 8'd0);
      f.ts_ok  = (mono_ts != 64'd0);
      f.len_ok = (f.plen <= 7'(MAX_PAYLOAD)) &&
                 !(f.first && !last_frame && f.plen < 7'(CRC_BYTES)) &&
                 !(f.idx == IDX_MASK && !last_frame);
   end

   assign full      = (cnt_ff == 2'd2);
   assign frm_valid = (cnt_ff != 2'd0);
   assign frm       = q_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = frm_take && frm_valid;
   assign wr_in     = do_push ? ~wr_ff : wr_ff;
   assign rd_in     = do_pop ? ~rd_ff : rd_ff;
   assign cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) q_ff[wr_ff] <= f;
   end

endmodule : mftr_front
`default_nettype wire

[hdl/mftr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mftr_back
// reassembly state, restart and accept decision, timing filter, result register
// ----------------------------------------------------------------------------
module mftr_back
   import mftr_pkg::*;
#(
   parameter int TID_BITS     = 3,
   parameter int INDEX_BITS   = 6,
   parameter int BUFFER_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] min_interval,
   input  wire logic [31:0] max_interval,
   input  wire logic        frm_valid,
   output logic             frm_take,
   input  wire frame_type   frm,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       status,
   output logic             drop_buffer,
   output logic             write_enable,
   output logic [9:0]       write_offset,
   output logic [1:0]       payload_skip,
   output logic [3:0]       write_len,
   output logic [15:0]      transfer_crc,
   output logic [63:0]      transfer_mono_ts,
   output logic [63:0]      transfer_utc_ts
);

   localparam logic [7:0]  TID_MASK = 8'((1 << TID_BITS) - 1);
   localparam logic [7:0]  IDX_MASK = 8'((1 << INDEX_BITS) - 1);
   localparam logic [7:0]  TID_HALF = 8'((1 << TID_BITS) / 2);
   localparam int          MULT     = (1 << TID_BITS) / 2 + 1;
   localparam int          PW       = $clog2(BUFFER_BYTES + 1) + 1;

   logic        init_ff, init_in;
   logic [1:0]  ciface_ff, ciface_in;
   logic [7:0]  etid_ff, etid_in, eidx_ff, eidx_in;
   logic [PW-1:0] wpos_ff, wpos_in;
   logic [15:0] crc_ff, crc_in;
   logic [63:0] this_ff, this_in, prev_ff, prev_in, utc_ff, utc_in;
   logic [31:0] avg_ff;
   // registered timeout limits, refreshed when avg changes
   logic [63:0] lim_recv_ff, lim_if_ff;
   // interval filter pipeline
   logic        tv_ff, tv_in;
   logic [63:0] tiv_ff, tiv_in;
   logic        fv_ff;
   logic [34:0] fsum_ff;
   logic        lim_stall;

   logic        ov_ff;
   logic [1:0]  st_ff, st_in, sk_ff, sk_in;
   logic        dr_ff, dr_in, we_ff, we_in;
   logic [9:0]  wo_ff, wo_in;
   logic [3:0]  wl_ff, wl_in;

   logic        go_step;
   logic [7:0]  tid_gap;
   logic        future, restart, go, ok, same_if;
   logic [63:0] age;
   logic [6:0]  n;
   logic [PW-1:0] npos;
   logic        upd;
   logic [63:0] iv;

   // filter runs two stages behind, timeouts update with avg; hold frames meanwhile
   assign lim_stall = tv_ff || fv_ff;
   assign empty     = !ov_ff;
   assign go_step   = frm_valid && (!ov_ff || pop) && !lim_stall;
   assign frm_take  = go_step;

   always_comb begin
      init_in = init_ff; ciface_in = ciface_ff; etid_in = etid_ff; eidx_in = eidx_ff;
      wpos_in = wpos_ff; crc_in = crc_ff; this_in = this_ff; prev_in = prev_ff;
      utc_in = utc_ff; tv_in = 1'b0; tiv_in = '0;
      st_in = STATUS_NONE; dr_in = 1'b0; we_in = 1'b0; wo_in = '0; sk_in = '0;
      wl_in = '0; upd = 1'b0; n = '0; npos = '0;
      tid_gap = (frm.tid - etid_ff) & TID_MASK;
      future  = (tid_gap != 8'd0) && (tid_gap < TID_HALF);
      age     = frm.mono - this_ff;
      same_if = (frm.iface == ciface_ff);
      restart = !init_ff || (age > lim_recv_ff) ||
                (same_if && frm.first && future) ||
                ((age > lim_if_ff) && frm.first && future);
      go = 1'b1;
      ok = 1'b0;
      if (frm.ts_ok && frm.mono >= prev_ff && frm.mono >= this_ff) begin
         if (restart) begin
            dr_in = 1'b1; init_in = 1'b1; ciface_in = frm.iface;
            etid_in = frm.tid; eidx_in = '0; wpos_in = '0; crc_in = '0;
            if (!frm.first) begin
               etid_in = (frm.tid + 8'd1) & TID_MASK;
               go = 1'b0;
            end
         end
         ok = go && (frm.iface == ciface_in) && frm.len_ok &&
              (frm.idx == eidx_in) && (frm.tid == etid_in);
         if (ok) begin
            if (frm.first) begin
               this_in = frm.mono;
               utc_in  = frm.utc;
            end
            if (frm.first && frm.last) begin
               dr_in = 1'b1; upd = 1'b1; crc_in = '0; st_in = STATUS_SINGLE;
               etid_in = (etid_in + 8'd1) & TID_MASK; eidx_in = '0; wpos_in = '0;
            end else begin
               n = frm.plen;
               if (frm.first) begin
                  crc_in = frm.head;
                  n = frm.plen - 7'(CRC_BYTES);
               end
               npos = wpos_in + PW'(n);
               if (npos <= PW'(BUFFER_BYTES)) begin
                  we_in = 1'b1; wo_in = 10'(wpos_in); wl_in = 4'(n);
                  sk_in = frm.first ? CRC_BYTES : 2'd0;
                  wpos_in = npos;
                  eidx_in = (eidx_in + 8'd1) & IDX_MASK;
                  if (frm.last) begin
                     upd = 1'b1; st_in = STATUS_MULTI;
                     etid_in = (etid_in + 8'd1) & TID_MASK; eidx_in = '0; wpos_in = '0;
                  end
               end else begin
                  dr_in = 1'b1;
                  etid_in = (etid_in + 8'd1) & TID_MASK; eidx_in = '0; wpos_in = '0;
               end
            end
         end
         if (upd) begin
            prev_in = this_in;
            if (prev_ff != 64'd0 && this_in != 64'd0 && this_in >= prev_ff) begin
               tv_in  = 1'b1;
               tiv_in = this_in - prev_ff;
            end
         end
      end
   end

   always_comb begin
      iv = tiv_ff;
      if (iv > 64'(max_interval)) iv = 64'(max_interval);
      if (iv < 64'(min_interval)) iv = 64'(min_interval);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b0; ciface_ff <= '0; etid_ff <= '0; eidx_ff <= '0;
         wpos_ff <= '0; crc_ff <= '0; this_ff <= '0; prev_ff <= '0; utc_ff <= '0;
         avg_ff <= AVG_INTERVAL_RESET;
         lim_recv_ff <= 64'(AVG_INTERVAL_RESET) * 64'(MULT);
         lim_if_ff <= 64'(AVG_INTERVAL_RESET) * 64'd2;
         tv_ff <= 1'b0; fv_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         if (go_step) begin
            init_ff <= init_in; ciface_ff <= ciface_in; etid_ff <= etid_in;
            eidx_ff <= eidx_in; wpos_ff <= wpos_in; crc_ff <= crc_in;
            this_ff <= this_in; prev_ff <= prev_in; utc_ff <= utc_in;
         end
         tv_ff <= go_step && tv_in;
         fv_ff <= tv_ff;
         if (fv_ff) begin
            avg_ff      <= 32'(fsum_ff >> 3);
            lim_recv_ff <= 64'(fsum_ff >> 3) * 64'(MULT);
            lim_if_ff   <= 64'(fsum_ff >> 3) * 64'd2;
         end
         if (go_step) ov_ff <= 1'b1;
         else if (pop) ov_ff <= 1'b0;
      end
      if (go_step) begin
         tiv_ff <= tiv_in;
         st_ff <= st_in; dr_ff <= dr_in; we_ff <= we_in; wo_ff <= wo_in;
         sk_ff <= sk_in; wl_ff <= wl_in;
      end
      if (tv_ff) fsum_ff <= 35'(avg_ff) * 35'd7 + 35'(iv[31:0]);
   end

   assign status           = st_ff;
   assign drop_buffer      = dr_ff;
   assign write_enable     = we_ff;
   assign write_offset     = wo_ff;
   assign payload_skip     = sk_ff;
   assign write_len        = wl_ff;
   assign transfer_crc     = crc_ff;
   assign transfer_mono_ts = this_ff;
   assign transfer_utc_ts  = utc_ff;

endmodule : mftr_back
`default_nettype wire

[hdl/multiframe_transfer_reassembly_fsm.sv]
// path: a pushed frame is stored in the front queue, then its result is registered
// throughput: one frame per cycle while results are popped; a frame that completes a
// transfer with a valid interval holds the next frame while the average updates
// reset: synchronous, clears queues, receiver state and restores register defaults
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiframe_transfer_reassembly_fsm
// multiframe transfer receiver: front queue and reassembly back end
// ----------------------------------------------------------------------------
module multiframe_transfer_reassembly_fsm
   import mftr_pkg::*;
#(
   parameter int TID_BITS     = 3,
   parameter int INDEX_BITS   = 6,
   parameter int BUFFER_BYTES = 512,
   parameter int MAX_PAYLOAD  = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_iface,
   input  wire logic [2:0]  req_transfer_id,
   input  wire logic [5:0]  req_frame_index,
   input  wire logic        req_last_frame,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic [15:0] req_head_bytes,
   input  wire logic [63:0] req_mono_ts,
   input  wire logic [63:0] req_utc_ts,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_status,
   output logic             rsp_drop_buffer,
   output logic             rsp_write_enable,
   output logic [9:0]       rsp_write_offset,
   output logic [1:0]       rsp_payload_skip,
   output logic [3:0]       rsp_write_len,
   output logic [15:0]      rsp_transfer_crc,
   output logic [63:0]      rsp_transfer_mono_ts,
   output logic [63:0]      rsp_transfer_utc_ts
);

   logic [31:0] min_ff, max_ff;
   logic        frm_valid, frm_take;
   frame_type   frm;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_INTERVAL_RESET;
         max_ff <= MAX_INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_INTERVAL: min_ff <= csr_data;
            CSR_MAX_INTERVAL: max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mftr_front #(.TID_BITS(TID_BITS), .INDEX_BITS(INDEX_BITS),
                .MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock, .reset, .push, .full,
      .iface(req_iface), .transfer_id(req_transfer_id), .frame_index(req_frame_index),
      .last_frame(req_last_frame), .byte_count(req_byte_count),
      .head_bytes(req_head_bytes), .mono_ts(req_mono_ts), .utc_ts(req_utc_ts),
      .frm_valid, .frm_take, .frm
   );

   mftr_back #(.TID_BITS(TID_BITS), .INDEX_BITS(INDEX_BITS),
               .BUFFER_BYTES(BUFFER_BYTES)) u_back (
      .clock, .reset, .min_interval(min_ff), .max_interval(max_ff),
      .frm_valid, .frm_take, .frm, .empty, .pop,
      .status(rsp_status), .drop_buffer(rsp_drop_buffer),
      .write_enable(rsp_write_enable), .write_offset(rsp_write_offset),
      .payload_skip(rsp_payload_skip), .write_len(rsp_write_len),
      .transfer_crc(rsp_transfer_crc), .transfer_mono_ts(rsp_transfer_mono_ts),
      .transfer_utc_ts(rsp_transfer_utc_ts)
   );

`ifndef ASSERT_OFF
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      frm_take |-> frm_valid) else $error("frame taken from empty queue");
   a_result_full: assert property (@(posedge clock) disable iff (reset)
      frm_take |=> !empty) else $error("result missing after frame");
   a_store_len: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_write_enable) |-> rsp_write_len <= 4'(MAX_PAYLOAD))
      else $error("store longer than frame payload");
`endif

endmodule : multiframe_transfer_reassembly_fsm
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the multiframe transfer receiver against a cycle-free predictor of
// its reassembly decisions, with random stalls on both queue interfaces
// ----------------------------------------------------------------------------
module testbench
   import mftr_pkg::*;
();

   typedef struct packed {
      logic [1:0]  iface;
      logic [2:0]  tid;
      logic [5:0]  idx;
      logic        last;
      logic [3:0]  plen;
      logic [15:0] head;
      logic [63:0] mono;
      logic [63:0] utc;
   } tb_frame_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        drop;
      logic        we;
      logic [9:0]  woff;
      logic [1:0]  skip;
      logic [3:0]  wlen;
      logic [15:0] crc;
      logic [63:0] mono;
      logic [63:0] utc;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [0:0] csr_index = CSR_MIN_INTERVAL;
   logic [31:0] csr_data = 0;
   logic push = 0;
   logic full;
   tb_frame_type req = '0;
   logic empty;
   logic pop = 0;
   wire verdict_type rsp;

   multiframe_transfer_reassembly_fsm uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .push(push), .full(full),
      .req_iface(req.iface), .req_transfer_id(req.tid), .req_frame_index(req.idx),
      .req_last_frame(req.last), .req_byte_count(req.plen),
      .req_head_bytes(req.head), .req_mono_ts(req.mono), .req_utc_ts(req.utc),
      .empty(empty), .pop(pop),
      .rsp_status(rsp.status), .rsp_drop_buffer(rsp.drop),
      .rsp_write_enable(rsp.we), .rsp_write_offset(rsp.woff),
      .rsp_payload_skip(rsp.skip), .rsp_write_len(rsp.wlen),
      .rsp_transfer_crc(rsp.crc), .rsp_transfer_mono_ts(rsp.mono),
      .rsp_transfer_utc_ts(rsp.utc)
   );

   initial forever #4 clock = ~clock;

   // predictor state
   logic [31:0] p_min, p_max, p_avg;
   logic        p_init;
   logic [1:0]  p_iface;
   logic [2:0]  p_tid;
   logic [5:0]  p_idx;
   logic [9:0]  p_wpos;
   logic [15:0] p_crc;
   logic [63:0] p_this, p_prev, p_utc;

   tb_frame_type pending_frames[$];
   verdict_type  expected_verdicts[$];
   int errors = 0, sent = 0, checked = 0, completes = 0, drops = 0;
   int rx_hold = 0;
   bit hold_done = 0;
   logic [63:0] now_ts = 64'd100;
   logic full_s = 0, empty_s = 1;

   task automatic reassembly_reset();
      p_min = MIN_INTERVAL_RESET; p_max = MAX_INTERVAL_RESET;
      p_avg = AVG_INTERVAL_RESET; p_init = 0; p_iface = 0; p_tid = 0;
      p_idx = 0; p_wpos = 0; p_crc = 0; p_this = 0; p_prev = 0; p_utc = 0;
   endtask

   function automatic void advance_transfer();
      p_tid = p_tid + 3'd1; p_idx = 0; p_wpos = 0;
   endfunction

   function automatic void update_interval();
      logic [63:0] older, iv;
      logic [66:0] acc;
      older = p_prev;
      p_prev = p_this;
      if (older != 0 && p_prev != 0 && p_prev >= older) begin
         iv = p_prev - older;
         if (iv > {32'd0, p_max}) iv = {32'd0, p_max};
         if (iv < {32'd0, p_min}) iv = {32'd0, p_min};
         acc = {35'd0, p_avg} * 67'd7 + {3'd0, iv};
         p_avg = acc[34:3];
      end
   endfunction

   function automatic verdict_type predict_verdict(tb_frame_type f);
      verdict_type v;
      logic first, future, restart, go, ok, recv_to, iface_to;
      logic [2:0] tid_gap;
      logic [63:0] age;
      logic [10:0] n;
      v = '0;
      if (f.mono != 0 && f.mono >= p_prev && f.mono >= p_this) begin
         first = f.idx == 0;
         tid_gap = f.tid - p_tid;
         future = tid_gap != 0 && tid_gap < 3'd4;
         age = f.mono - p_this;
         recv_to = age > {32'd0, p_avg} * 64'd5;
         iface_to = age > {32'd0, p_avg} * 64'd2;
         restart = !p_init || recv_to || (f.iface == p_iface && first && future)
                   || (iface_to && first && future);
         go = 1;
         if (restart) begin
            v.drop = 1; p_init = 1; p_iface = f.iface; p_tid = f.tid;
            p_idx = 0; p_wpos = 0; p_crc = 0;
            if (!first) begin
               p_tid = p_tid + 3'd1; go = 0;
            end
         end
         if (go) begin
            ok = f.iface == p_iface && f.plen <= 4'd8 &&
                 !(first && !f.last && f.plen < 4'd2) &&
                 !(f.idx == 6'h3f && !f.last) && f.idx == p_idx && f.tid == p_tid;
            if (ok) begin
               if (first) begin
                  p_this = f.mono; p_utc = f.utc;
               end
               if (first && f.last) begin
                  v.drop = 1; update_interval(); advance_transfer();
                  p_crc = 0; v.status = STATUS_SINGLE;
               end else begin
                  n = {7'd0, f.plen};
                  if (first) begin
                     p_crc = f.head; n = n - 11'd2;
                  end
                  if ({1'b0, p_wpos} + n <= 11'd512) begin
                     v.we = 1; v.woff = p_wpos; v.wlen = n[3:0];
                     v.skip = first ? CRC_BYTES : 2'd0;
                     p_wpos = p_wpos + n[9:0]; p_idx = p_idx + 6'd1;
                     if (f.last) begin
                        update_interval(); advance_transfer(); v.status = STATUS_MULTI;
                     end
                  end else begin
                     v.drop = 1; advance_transfer();
                  end
               end
            end
         end
      end
      v.crc = p_crc; v.mono = p_this; v.utc = p_utc;
      return v;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch at transaction %0d: %s got %0h expected %0h",
               checked, what, got, want);
   endtask

   // driver
   int tx_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (push && !full_s) begin
            sent++;
            tx_gap = $urandom_range(0, 3);
         end
         if (push && full_s) begin
            // keep offering
         end else if (tx_gap > 0 || pending_frames.size() == 0) begin
            if (tx_gap > 0) tx_gap--;
            push <= 0;
         end else begin
            req <= pending_frames.pop_front();
            push <= 1;
         end
      end
   end

   always @(posedge clock) begin
      full_s <= full;
      empty_s <= empty;
      if (!reset && push && !full) expected_verdicts.push_back(predict_verdict(req));
   end

   // monitor
   int rx_gap = 0;
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         checked++;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected transaction", 64'd0, 64'd0);
         end else begin
            verdict_type w;
            w = expected_verdicts.pop_front();
            if (rsp.status == STATUS_MULTI) completes++;
            if (rsp.drop) drops++;
            if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
            if (rsp.drop !== w.drop) report_mismatch("drop_buffer", rsp.drop, w.drop);
            if (rsp.we !== w.we) report_mismatch("write_enable", rsp.we, w.we);
            if (rsp.woff !== w.woff) report_mismatch("write_offset", rsp.woff, w.woff);
            if (rsp.skip !== w.skip) report_mismatch("payload_skip", rsp.skip, w.skip);
            if (rsp.wlen !== w.wlen) report_mismatch("write_len", rsp.wlen, w.wlen);
            if (rsp.crc !== w.crc) report_mismatch("transfer_crc", rsp.crc, w.crc);
            if (rsp.mono !== w.mono) report_mismatch("transfer_mono_ts", rsp.mono, w.mono);
            if (rsp.utc !== w.utc) report_mismatch("transfer_utc_ts", rsp.utc, w.utc);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (pop && !empty_s) rx_gap = $urandom_range(0, 3);
         if (rx_hold > 0) begin
            rx_hold--;
            pop <= 0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 0;
         end else begin
            pop <= 1;
         end
      end
   end

   task automatic add_frame(logic [1:0] ifc, logic [2:0] tid, logic [5:0] idx,
                            logic last, logic [3:0] plen, logic [63:0] step);
      tb_frame_type f;
      now_ts = now_ts + step;
      f.iface = ifc; f.tid = tid; f.idx = idx; f.last = last; f.plen = plen;
      f.head = 16'($urandom); f.mono = now_ts;
      f.utc = {$urandom, $urandom};
      pending_frames.push_back(f);
   endtask

   task automatic drain();
      wait (pending_frames.size() == 0 && !push);
      wait (expected_verdicts.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_we <= 0;
      if (idx == CSR_MIN_INTERVAL) p_min = val; else p_max = val;
   endtask

   // one well-formed transfer with random content, optionally corrupted
   task automatic add_transfer(logic [1:0] ifc, logic [2:0] tid, int frames, bit noisy);
      for (int k = 0; k < frames; k++) begin
         logic [5:0] idx;
         logic [3:0] plen;
         idx = 6'(k);
         plen = 4'((k == 0) ? $urandom_range(2, 8) : $urandom_range(0, 8));
         if (noisy && $urandom_range(0, 5) == 0) idx = 6'($urandom);
         if (noisy && $urandom_range(0, 9) == 0) plen = 4'($urandom);
         add_frame(noisy && $urandom_range(0, 9) == 0 ? 2'($urandom) : ifc,
                   tid, idx, k == frames - 1, plen, 64'($urandom_range(1, 3000)));
      end
   endtask

   task automatic random_phase(int count);
      logic [2:0] tid;
      tid = 3'($urandom);
      while (count > 0) begin
         int r, nf;
         r = $urandom_range(0, 9);
         if (r < 7) begin
            nf = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70)
                                              : $urandom_range(1, 6);
            add_transfer(2'($urandom_range(0, 1)), tid, nf, r == 6);
            tid = tid + (($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd1);
            count -= nf;
         end else begin
            tb_frame_type f;
            f = tb_frame_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
            f.plen = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0) f.mono = 0;
            else if ($urandom_range(0, 1)) f.mono = now_ts + 64'($urandom_range(0, 40000000));
            else f.mono = {$urandom, $urandom};
            if (f.mono > now_ts) now_ts = f.mono;
            pending_frames.push_back(f);
            count--;
         end
      end
   endtask

   initial begin
      reassembly_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: single frame, multi frame, stray non-first frame, bad ts,
      // oversized payload, short first frame, max index, long run past max index
      add_frame(0, 0, 0, 1, 0, 10);
      add_frame(0, 1, 0, 0, 8, 100);
      add_frame(0, 1, 1, 0, 8, 100);
      add_frame(0, 1, 2, 1, 3, 100);
      add_frame(1, 5, 3, 0, 4, 100);
      add_frame(0, 2, 0, 1, 15, 100);
      add_frame(0, 2, 0, 0, 1, 100);
      add_frame(0, 2, 63, 0, 8, 100);
      add_frame(3, 7, 0, 1, 8, 100);
      begin
         tb_frame_type f;
         f = '1; f.mono = 0; pending_frames.push_back(f);
         f.mono = 64'd5; pending_frames.push_back(f);
      end
      add_frame(0, 6, 0, 0, 8, 100);
      for (int k = 1; k < 66; k++) add_frame(0, 6, 6'(k), 0, 8, 50);
      add_frame(0, 7, 0, 1, 2, 100000000);
      add_transfer(2, 3, 4, 0);
      drain();

      write_reg(CSR_MIN_INTERVAL, 32'hffff_ffff);
      write_reg(CSR_MAX_INTERVAL, 32'd0);
      random_phase(200);
      drain();
      write_reg(CSR_MIN_INTERVAL, 32'd0);
      write_reg(CSR_MAX_INTERVAL, 32'hffff_ffff);
      random_phase(200);
      // long receiver stall while frames keep coming
      rx_hold = 300;
      random_phase(150);
      drain();
      write_reg(CSR_MIN_INTERVAL, MIN_INTERVAL_RESET);
      write_reg(CSR_MAX_INTERVAL, MAX_INTERVAL_RESET);
      random_phase(400);
      drain();
      write_reg(CSR_MIN_INTERVAL, $urandom_range(0, 5000));
      write_reg(CSR_MAX_INTERVAL, $urandom_range(0, 5000));
      random_phase(300);
      drain();

      $display("sent %0d frames, checked %0d results, %0d multi-frame completions",
               sent, checked, completes);
      $display("%0d buffer drops seen across five interval settings", drops);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[multiframe_transfer_reassembly_fsm.f]
hdl/mftr_pkg.sv
hdl/mftr_front.sv
hdl/mftr_back.sv
hdl/multiframe_transfer_reassembly_fsm.sv
tb/testbench.sv
